@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // field widths fixed by the stream format
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 2 * CHAR_W + COL_W + ROW_W + 1;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_NULL    = 8'd0;
  localparam logic [CHAR_W-1:0] CODE_HALT    = 8'd3;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'd7;

  typedef struct packed {
    logic              char_we;
    logic              attr_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_char;
    logic [CHAR_W-1:0] wr_attr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic              halted;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
`default_nettype none

// Text console writer: an 80x25 character console kept in an on-chip cell
// store (character byte plus attribute byte per cell), with a cursor and a
// sticky halt flag. Every input beat gives exactly one output beat carrying
// the read cell (zero unless a read command), the cursor after the command
// and the halt flag; tlast is echoed. A put, a read, a null or halt code and
// a clear while halted pass through the execute and result states into the
// output register; in_tready rises again in the same cycle as out_tvalid,
// and a full output register holds the result state. A put that moves
// past the bottom row scrolls the screen: the character array is walked
// one cell per cycle, reading one row ahead and writing back, then the
// bottom row is blanked. A clear that is not halted sweeps every cell once.
// The store has a single write port, so scroll and clear go cell by cell.
// After reset a clearing pass over all CELLS cells fills the store before
// in_tready rises. One command is in work at a time; a finished result
// waits in the output register while the next beat is accepted.

module text_console_writer_core (
  input  wire                               clk,
  input  wire                               rst_n,
  // in_tdata: char_code[7:0], cell_index[18:8], zero [23:19]
  input  wire [tcw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: command[1:0]
  input  wire [tcw_pkg::CMD_W-1:0]          in_tuser,
  input  wire                               in_tlast,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // out_tdata: cell_char[7:0], cell_attr[15:8], cursor_col[22:16],
  //            cursor_row[27:23], halted[28], zero [31:29]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  wire                               out_tready
);
  import tcw_pkg::*;

  logic              in_take;
  logic              idle;
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] rd_char;
  logic [CHAR_W-1:0] rd_attr;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              res_run;
  logic              halt;

  logic                   out_valid_r;
  logic [OUT_USED_W-1:0]  out_data_r;
  logic                   out_last_r;

  assign in_tready = idle;
  assign in_take   = in_tvalid && idle;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_cmd    (in_tuser),
    .in_code   (in_tdata[CHAR_W-1:0]),
    .in_idx    (in_tdata[CHAR_W+IDX_W-1:CHAR_W]),
    .in_run    (in_tlast),
    .idle      (idle),
    .mem_req   (mem_req),
    .rd_char   (rd_char),
    .rd_attr   (rd_attr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .res_run   (res_run),
    .halt      (halt)
  );

  tcw_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_char (rd_char),
    .rd_attr (rd_attr)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
      out_last_r <= res_run;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // one command in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat accepted while a command is in work");

  // the store is never written while waiting for a command
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(mem_req.char_we || mem_req.attr_we))
    else $error("cell store written while idle");

  // halt is cleared only by reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(halt) |-> halt)
    else $error("halt flag dropped without reset");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) || !$past(res_valid))
    else $error("stalled output beat overwritten");
`endif

endmodule

`default_nettype wire

@@ rtl/tcw_store.sv @@
`default_nettype none

module tcw_store (
  input  wire                           clk,
  input  wire tcw_pkg::mem_req_t        req,
  output logic [tcw_pkg::CHAR_W-1:0]    rd_char,
  output logic [tcw_pkg::CHAR_W-1:0]    rd_attr
);
  import tcw_pkg::*;

  // characters and attributes in separate arrays: scroll moves only characters
  logic [CHAR_W-1:0] char_mem [CELLS];
  logic [CHAR_W-1:0] attr_mem [CELLS];
  logic [CHAR_W-1:0] rd_char_r;
  logic [CHAR_W-1:0] rd_attr_r;

  always_ff @(posedge clk) begin
    if (req.char_we) begin
      char_mem[req.wr_addr] <= req.wr_char;
    end
    if (req.attr_we) begin
      attr_mem[req.wr_addr] <= req.wr_attr;
    end
    if (req.rd_en) begin
      rd_char_r <= char_mem[req.rd_addr];
      rd_attr_r <= attr_mem[req.rd_addr];
    end
  end

  assign rd_char = rd_char_r;
  assign rd_attr = rd_attr_r;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_take,
  input  wire [tcw_pkg::CMD_W-1:0]    in_cmd,
  input  wire [tcw_pkg::CHAR_W-1:0]   in_code,
  input  wire [tcw_pkg::IDX_W-1:0]    in_idx,
  input  wire                         in_run,
  output logic                        idle,
  output tcw_pkg::mem_req_t           mem_req,
  input  wire [tcw_pkg::CHAR_W-1:0]   rd_char,
  input  wire [tcw_pkg::CHAR_W-1:0]   rd_attr,
  output logic                        res_valid,
  input  wire                         res_ready,
  output tcw_pkg::result_t            res,
  output logic                        res_run,
  output logic                        halt
);
  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              init_r, init_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              halt_r, halt_nxt;

  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] code_r;
  logic [IDX_W-1:0]  idx_r;
  logic              run_r;

  logic              idx_ok;
  logic [ADDR_W-1:0] cursor_addr;
  logic              next_row;

  assign idx_ok      = 32'(idx_r) < CELLS;
  assign cursor_addr = ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      init_r  <= 1'b1;
      col_r   <= '0;
      row_r   <= '0;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      init_r  <= init_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      halt_r  <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_cmd;
      code_r <= in_code;
      idx_r  <= in_idx;
      run_r  <= in_run;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    init_nxt  = init_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    halt_nxt  = halt_r;
    next_row  = 1'b0;
    mem_req   = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.char_we = 1'b1;
        mem_req.attr_we = 1'b1;
        mem_req.wr_addr = ptr_r;
        mem_req.wr_char = BLANK_CHAR;
        mem_req.wr_attr = BLANK_ATTR;
        ptr_nxt         = ptr_r + ADDR_W'(1);
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_RESULT;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESULT;
        unique case (cmd_r)
          CMD_PUT: begin
            if (code_r == CODE_HALT) begin
              halt_nxt = 1'b1;
            end else if (!halt_r) begin
              if (code_r == CODE_NEWLINE) begin
                col_nxt  = '0;
                next_row = 1'b1;
              end else if (code_r != CODE_NULL) begin
                mem_req.char_we = 1'b1;
                mem_req.wr_addr = cursor_addr;
                mem_req.wr_char = code_r;
                if (col_r == LAST_COL) begin
                  col_nxt  = '0;
                  next_row = 1'b1;
                end else begin
                  col_nxt = col_r + COL_W'(1);
                end
              end
            end
            if (next_row) begin
              if (row_r == LAST_ROW) begin
                ptr_nxt   = '0;
                state_nxt = S_SCROLL;
              end else begin
                row_nxt = row_r + ROW_W'(1);
              end
            end
          end
          CMD_CLEAR: begin
            col_nxt = '0;
            row_nxt = '0;
            if (!halt_r) begin
              ptr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
          end
          CMD_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ok ? idx_r[ADDR_W-1:0] : '0;
          end
          default: begin
          end
        endcase
      end
      S_SCROLL: begin
        // read one row ahead, write the character read last cycle one row up
        if (ptr_r != '0) begin
          mem_req.char_we = 1'b1;
          mem_req.wr_addr = ptr_r - ADDR_W'(1);
          mem_req.wr_char = rd_char;
        end
        if (ptr_r == BOTTOM_ROW) begin
          state_nxt = S_BLANK;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_r + ROW_STRIDE;
          ptr_nxt         = ptr_r + ADDR_W'(1);
        end
      end
      S_BLANK: begin
        mem_req.char_we = 1'b1;
        mem_req.wr_addr = ptr_r;
        mem_req.wr_char = BLANK_CHAR;
        ptr_nxt         = ptr_r + ADDR_W'(1);
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle      = state_r == S_IDLE;
  assign res_valid = state_r == S_RESULT;
  assign halt      = halt_r;
  assign res_run   = run_r;

  always_comb begin
    res            = '0;
    res.cursor_col = col_r;
    res.cursor_row = row_r;
    res.halted     = halt_r;
    if (cmd_r == CMD_READ && idx_ok) begin
      res.cell_char = rd_char;
      res.cell_attr = rd_attr;
    end
  end

endmodule

`default_nettype wire
